/* rtl/signed_int_to_decimal_ascii_top_defines.svh */
// Assertion macros shared by the signed integer to decimal text converter.
// Included by the modules that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SITDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SITDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sitda_pkg.sv */
// Shared types and constants of the signed integer to decimal text converter.
// No dependencies; used by every module of the block.
package sitda_pkg;

  // Magnitude bits consumed by one shift-and-add-three pipeline stage.
  localparam int unsigned BitsPerStage = 4;

  localparam logic [5:0] CharMinus = 6'd45;
  localparam logic [5:0] CharZero  = 6'd48;

  typedef logic [3:0] digit_t;

  // One character on its way to the result channel.
  typedef struct packed {
    logic [5:0] code;
    logic       last;
  } char_t;

endpackage

/* rtl/sitda_dabble_stage.sv */
// One registered stage of the binary to BCD converter (shift and add three).
// Depends on sitda_pkg for the number of bits handled per stage.
module sitda_dabble_stage #(
  parameter int unsigned DIGITS = 10,
  parameter int unsigned BIN_W  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  in_neg_i,
  input  logic [BIN_W-1:0]      in_bin_i,
  input  logic [DIGITS*4-1:0]   in_bcd_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  out_neg_o,
  output logic [BIN_W-1:0]      out_bin_o,
  output logic [DIGITS*4-1:0]   out_bcd_o
);

  localparam int unsigned DigitW = DIGITS * 4;

  logic              valid_q, valid_d;
  logic              neg_q;
  logic [BIN_W-1:0]  bin_q, bin_d;
  logic [DigitW-1:0] bcd_q, bcd_d;

  // Each step corrects every digit of five or more, then shifts one magnitude bit in.
  always_comb begin
    bcd_d = in_bcd_i;
    bin_d = in_bin_i;
    for (int s = 0; s < sitda_pkg::BitsPerStage; s++) begin
      for (int d = 0; d < DIGITS; d++) begin
        if (bcd_d[d*4 +: 4] >= 4'd5) begin
          bcd_d[d*4 +: 4] = bcd_d[d*4 +: 4] + 4'd3;
        end
      end
      {bcd_d, bin_d} = {bcd_d[DigitW-2:0], bin_d, 1'b0};
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      neg_q <= in_neg_i;
      bin_q <= bin_d;
      bcd_q <= bcd_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_neg_o   = neg_q;
  assign out_bin_o   = bin_q;
  assign out_bcd_o   = bcd_q;

endmodule

/* rtl/sitda_serializer.sv */
// Turns one converted number (sign and BCD digits) into a run of ASCII characters.
// Depends on sitda_pkg and the assertion macros in signed_int_to_decimal_ascii_top_defines.svh.
`include "signed_int_to_decimal_ascii_top_defines.svh"

module sitda_serializer #(
  parameter int unsigned DIGITS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                in_neg_i,
  input  logic [DIGITS*4-1:0] in_bcd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sitda_pkg::char_t    out_char_o
);

  localparam int unsigned IdxW = $clog2(DIGITS);

  logic                busy_q, busy_d;
  logic                neg_q, neg_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [IdxW-1:0]     msd;
  sitda_pkg::digit_t   digits_q [DIGITS];
  logic                out_valid_q, out_valid_d;
  sitda_pkg::char_t    char_q, char_d;
  logic                load_in, load_out, final_char;

  // Position of the most significant non-zero digit; zero itself gives position 0.
  always_comb begin
    msd = '0;
    for (int d = 0; d < DIGITS; d++) begin
      if (in_bcd_i[d*4 +: 4] != 4'd0) begin
        msd = IdxW'(d);
      end
    end
  end

  assign in_ready_o = !busy_q;
  assign load_in    = in_valid_i && !busy_q;
  assign load_out   = busy_q && (!out_valid_q || out_ready_i);
  assign final_char = !neg_q && (idx_q == '0);

  always_comb begin
    busy_d      = busy_q;
    neg_d       = neg_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    char_d      = char_q;
    if (load_in) begin
      busy_d = 1'b1;
      neg_d  = in_neg_i;
      idx_d  = msd;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
      if (neg_q) begin
        char_d.code = sitda_pkg::CharMinus;
        char_d.last = 1'b0;
        neg_d       = 1'b0;
      end else begin
        char_d.code = sitda_pkg::CharZero + {2'b00, digits_q[idx_q]};
        char_d.last = final_char;
        if (final_char) begin
          busy_d = 1'b0;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    char_q <= char_d;
    if (load_in) begin
      for (int d = 0; d < DIGITS; d++) begin
        digits_q[d] <= in_bcd_i[d*4 +: 4];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = char_q;

  `SITDA_ASSERT_NOW(a_char_range, out_valid_q,
    (char_q.code == sitda_pkg::CharMinus) ||
    ((char_q.code >= sitda_pkg::CharZero) && (char_q.code <= sitda_pkg::CharZero + 6'd9)),
    "character code is neither a minus sign nor a digit")
  `SITDA_ASSERT_NOW(a_minus_not_last, out_valid_q && (char_q.code == sitda_pkg::CharMinus),
    !char_q.last, "minus sign flagged as final character")
  `SITDA_ASSERT_NEXT(a_load_busy, in_valid_i && in_ready_o, busy_q,
    "accepted number did not occupy the serializer")
  `SITDA_ASSERT_NEXT(a_final_frees, load_out && final_char, !busy_q && out_char_o.last,
    "final character did not release the serializer")

endmodule

/* rtl/signed_int_to_decimal_ascii_top.sv */
// Top level of the signed integer to decimal ASCII converter.
// Depends on sitda_pkg, sitda_dabble_stage and sitda_serializer.
//
// Each input transaction carries one two's-complement integer of VALUE_WIDTH bits in the low
// bits of s_axis_tdata_i (higher bits are ignored). The block answers with its decimal text,
// one ASCII character per output transaction: a minus sign for negative values, then the
// digits most significant first without leading zeros, and tlast on the final character. Zero
// gives the single character "0", and the most negative value is printed in full. Nothing is
// kept from one number to the next. Internally an input register forms sign and magnitude,
// a pipeline of ceil(VALUE_WIDTH/4) shift-and-add-three stages turns the magnitude into BCD
// (four bits per stage), and a serializer with its own output register emits the characters.
// The first character passes the input register, each stage register, the serializer's
// digit register and its output register in turn. The serializer sets the throughput: it
// takes a new number only once the final character of the last one is in its output
// register. The pipeline in front of it keeps taking numbers while the serializer is busy
// until every stage is full.
module signed_int_to_decimal_ascii_top #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // value (VALUE_WIDTH bits, signed), zero padding above to whole bytes
  input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // char_code [5:0], zero padding [7:6]
  output logic [7:0]                           m_axis_tdata_o,
  // last_char
  output logic                                 m_axis_tlast_o
);

  // Decimal digits needed for VALUE_WIDTH bits: floor(VALUE_WIDTH * log10(2)) + 1.
  localparam int unsigned NumDigits = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned DigitW    = NumDigits * 4;
  localparam int unsigned NumStages =
    (VALUE_WIDTH + sitda_pkg::BitsPerStage - 1) / sitda_pkg::BitsPerStage;
  localparam int unsigned PadW      = NumStages * sitda_pkg::BitsPerStage;

  // Input register: sign and magnitude of the accepted value.
  logic                   in_valid_q;
  logic                   in_neg_q;
  logic [VALUE_WIDTH-1:0] in_mag_q;
  logic [VALUE_WIDTH-1:0] raw, mag;

  // Handshake and payload between consecutive stages; index 0 is the input register.
  logic              stg_valid [NumStages+1];
  logic              stg_ready [NumStages+1];
  logic              stg_neg   [NumStages+1];
  logic [PadW-1:0]   stg_bin   [NumStages+1];
  logic [DigitW-1:0] stg_bcd   [NumStages+1];

  sitda_pkg::char_t  ser_char;

  // The magnitude is taken as an unsigned number of VALUE_WIDTH bits, so negating the most
  // negative value wraps to the correct unsigned magnitude.
  assign raw = s_axis_tdata_i[VALUE_WIDTH-1:0];
  assign mag = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;

  assign s_axis_tready_o = !in_valid_q || stg_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_neg_q <= raw[VALUE_WIDTH-1];
      in_mag_q <= mag;
    end
  end

  assign stg_valid[0] = in_valid_q;
  assign stg_neg[0]   = in_neg_q;
  assign stg_bin[0]   = PadW'(in_mag_q);
  assign stg_bcd[0]   = '0;

  // Each stage shifts four magnitude bits into the BCD digits.
  for (genvar g = 0; g < NumStages; g++) begin : g_dabble
    sitda_dabble_stage #(
      .DIGITS (NumDigits),
      .BIN_W  (PadW)
    ) u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (stg_valid[g]),
      .in_ready_o  (stg_ready[g]),
      .in_neg_i    (stg_neg[g]),
      .in_bin_i    (stg_bin[g]),
      .in_bcd_i    (stg_bcd[g]),
      .out_valid_o (stg_valid[g+1]),
      .out_ready_i (stg_ready[g+1]),
      .out_neg_o   (stg_neg[g+1]),
      .out_bin_o   (stg_bin[g+1]),
      .out_bcd_o   (stg_bcd[g+1])
    );
  end

  // The serializer walks the digits from the most significant non-zero one downwards.
  sitda_serializer #(
    .DIGITS (NumDigits)
  ) u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (stg_valid[NumStages]),
    .in_ready_o  (stg_ready[NumStages]),
    .in_neg_i    (stg_neg[NumStages]),
    .in_bcd_i    (stg_bcd[NumStages]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_char_o  (ser_char)
  );

  assign m_axis_tdata_o = {2'b00, ser_char.code};
  assign m_axis_tlast_o = ser_char.last;

endmodule

/* tb/tb_signed_int_to_decimal_ascii_top.sv */
// Self-checking testbench for signed_int_to_decimal_ascii_top: integers go in on the input
// stream and every output character is checked against a built-in decimal text predictor.
// Depends on sitda_pkg and the top level module only.
module tb_signed_int_to_decimal_ascii_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned TDATA_W     = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int unsigned RADIX       = 10;
  localparam int unsigned MAX_DIGITS  = 10;
  // Watchdog limit, set to many times the length of the slowest correct run.
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned TAIL_CYCLES = 40;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid_i;
  logic               s_axis_tready_o;
  logic [TDATA_W-1:0] s_axis_tdata_i;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i;
  logic [7:0]         m_axis_tdata_o;
  logic               m_axis_tlast_o;

  // Characters still owed by the block, oldest first.
  sitda_pkg::char_t pending_chars[$];
  int unsigned      send_idle_pct;
  int unsigned      sink_stall_pct;
  int unsigned      cycle_count;
  int unsigned      error_count;
  int unsigned      numbers_sent;
  int unsigned      negatives_sent;
  int unsigned      chars_checked;
  int unsigned      longest_text;

  signed_int_to_decimal_ascii_top #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    send_idle_pct   = 0;
    sink_stall_pct  = 0;
    cycle_count     = 0;
    error_count     = 0;
    numbers_sent    = 0;
    negatives_sent  = 0;
    chars_checked   = 0;
    longest_text    = 0;
  end

  always #5 clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d characters outstanding", $time,
               pending_chars.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Works out the decimal text of one accepted value and queues its characters. The magnitude
  // is formed in VALUE_WIDTH unsigned bits, so the most negative value comes out in full.
  function automatic void predict_decimal_text(input logic [VALUE_WIDTH-1:0] value);
    logic [VALUE_WIDTH-1:0] magnitude;
    sitda_pkg::digit_t      digits[MAX_DIGITS];
    int                     ndigits;
    int                     k;
    sitda_pkg::char_t       c;
    magnitude = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
    ndigits   = 0;
    do begin
      digits[ndigits] = sitda_pkg::digit_t'(magnitude % RADIX);
      magnitude       = magnitude / RADIX;
      ndigits++;
    end while (magnitude != 0);
    if (value[VALUE_WIDTH-1]) begin
      c.code = sitda_pkg::CharMinus;
      c.last = 1'b0;
      pending_chars.push_back(c);
      negatives_sent++;
    end
    for (k = ndigits - 1; k >= 0; k--) begin
      c.code = sitda_pkg::CharZero + 6'(digits[k]);
      c.last = (k == 0);
      pending_chars.push_back(c);
    end
    if (ndigits + value[VALUE_WIDTH-1] > longest_text)
      longest_text = ndigits + value[VALUE_WIDTH-1];
  endfunction

  function automatic longint unsigned power_of_ten(input int unsigned n);
    longint unsigned p;
    p = 1;
    repeat (n) p = p * RADIX;
    return p;
  endfunction

  // Random values spread over text lengths, with plenty of edge values mixed in.
  function automatic logic [VALUE_WIDTH-1:0] random_value();
    longint unsigned magnitude;
    int unsigned     ndigits;
    logic            negative;
    negative = 1'($urandom_range(1));
    case ($urandom_range(5))
      0: return VALUE_WIDTH'($urandom);
      1: magnitude = $urandom_range(99);
      2: magnitude = power_of_ten($urandom_range(9));
      3: magnitude = power_of_ten($urandom_range(1, 9)) - 1;
      4: return negative ? {1'b1, {(VALUE_WIDTH-1){1'b0}}} : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
      default: begin
        ndigits   = $urandom_range(1, MAX_DIGITS);
        magnitude = {$urandom, $urandom};
        magnitude = magnitude % power_of_ten(ndigits);
        magnitude = magnitude % 64'h8000_0000;
      end
    endcase
    return negative ? VALUE_WIDTH'(-magnitude) : VALUE_WIDTH'(magnitude);
  endfunction

  // Sends one value on the input stream. Called at a rising edge and returns at the edge that
  // completes the transaction; tvalid is left high so a following call can stream on.
  task automatic send_value(input logic [VALUE_WIDTH-1:0] value);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= TDATA_W'($urandom);
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= TDATA_W'(value);
    // Inputs only move at rising edges, so tready seen at the falling edge holds at the next one.
    @(negedge clk_i);
    while (!s_axis_tready_o) @(negedge clk_i);
    predict_decimal_text(value);
    numbers_sent++;
    @(posedge clk_i);
  endtask

  // Drops tvalid and holds the sender back until every owed character has been taken.
  task automatic wait_text_drained();
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= TDATA_W'($urandom);
    @(posedge clk_i);
    while (pending_chars.size() != 0) @(posedge clk_i);
  endtask

  // The sink stalls at random; tready is only moved at rising edges.
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Output transactions are recognised at the falling edge, where the values that the next
  // rising edge will take are already stable.
  always @(negedge clk_i) begin
    sitda_pkg::char_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      chars_checked++;
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual code %0d last %0b", $time,
                 m_axis_tdata_o, m_axis_tlast_o);
        error_count++;
      end else begin
        want = pending_chars.pop_front();
        if (m_axis_tdata_o !== {2'b00, want.code}) begin
          $display("%0t: char_code mismatch: expected %0d, actual %0d", $time,
                   {2'b00, want.code}, m_axis_tdata_o);
          error_count++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $display("%0t: last_char mismatch: expected %0b, actual %0b", $time, want.last,
                   m_axis_tlast_o);
          error_count++;
        end
      end
    end
  end

  // Extremes, zero, single digits, the power-of-ten boundaries at 10, 100 and 10^9, and both signs.
  task automatic test_directed_values();
    logic [VALUE_WIDTH-1:0] values[$];
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    values = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd99,
               32'sd100, -32'sd100, 32'sd123456789, -32'sd987654321, 32'sd1000000000,
               -32'sd1000000000, 32'sd999999999, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h8000_0001, 32'sd2000000000, -32'sd7, 32'hAAAA_AAAA, 32'h5555_5555};
    foreach (values[i]) send_value(values[i]);
    wait_text_drained();
  endtask

  // Random values with random gaps on both sides, drained now and then.
  task automatic test_random_with_idling();
    send_idle_pct  = 25;
    sink_stall_pct = 25;
    for (int n = 0; n < 130; n++) begin
      send_value(random_value());
      if (n % 45 == 44) wait_text_drained();
    end
  endtask

  // A long stretch with no idling anywhere, so numbers stream back to back.
  task automatic test_back_to_back();
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    for (int n = 0; n < 60; n++) send_value(random_value());
  endtask

  // Sender never idles while the sink stalls, so the pipeline fills and tready drops.
  task automatic test_stalled_sink();
    send_idle_pct  = 0;
    sink_stall_pct = 25;
    for (int n = 0; n < 40; n++) send_value(random_value());
    wait_text_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_values();
    test_random_with_idling();
    test_back_to_back();
    test_stalled_sink();

    wait_text_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Converted %0d integers (%0d negative), checked %0d characters, longest text %0d.",
             numbers_sent, negatives_sent, chars_checked, longest_text);
    $display("Phases: directed edge values, random with idling, back to back, stalled sink.");
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* signed_int_to_decimal_ascii_top.f */
+incdir+rtl
rtl/sitda_pkg.sv
rtl/sitda_dabble_stage.sv
rtl/sitda_serializer.sv
rtl/signed_int_to_decimal_ascii_top.sv
tb/tb_signed_int_to_decimal_ascii_top.sv
